// ===== hdl/ard_gaussian_kernel_defines.svh =====
// assertion macros used by the kernel datapath
`ifndef ARD_GAUSSIAN_KERNEL_DEFINES_SVH
`define ARD_GAUSSIAN_KERNEL_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ARD_GK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ARD_GK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ard_gk_pkg.sv =====
// types, constants and tables of the ard gaussian kernel
package ard_gk_pkg;

    localparam int SUM_W     = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [14:0]      DIFF_MAX  = 15'h7FFF;
    localparam logic [16:0]      LOG2E_Q16 = 17'd94548;
    localparam logic [30:0]      EXP_ONE   = 31'h4000_0000;
    localparam logic [60:0]      EXP_RND   = 61'h2000_0000;
    localparam logic [16:0]      EXP_MAX   = 17'h1_0000;
    localparam logic [15:0]      SV_RESET  = 16'd256;
    localparam logic [15:0]      NV_RESET  = 16'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_VAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_VAR  = 1'b1;

    typedef struct packed {
        logic signed [15:0] coord_a;
        logic signed [15:0] coord_b;
        logic [15:0]        inv_length_scale;
        logic               skip;
        logic               on_diagonal;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [32:0] kernel_value;
        logic        saturated;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scale;
        logic square;
        logic accum;
        logic log_lo;
        logic log_hi;
        logic log_sum;
        logic exp_step;
        logic exp_final;
        logic amp;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic exp_last;
        logic out_free;
    } t_dp_status;

    // 2^-(2^-(j+1)) in q0.30
    function automatic logic [29:0] pow2_neg_frac(input logic [3:0] j);
        logic [29:0] c;
        case (j)
            4'd0:    c = 30'd759250125;
            4'd1:    c = 30'd902905651;
            4'd2:    c = 30'd984625594;
            4'd3:    c = 30'd1028218693;
            4'd4:    c = 30'd1050733751;
            4'd5:    c = 30'd1062175491;
            4'd6:    c = 30'd1067942999;
            4'd7:    c = 30'd1070838486;
            4'd8:    c = 30'd1072289173;
            4'd9:    c = 30'd1073015252;
            4'd10:   c = 30'd1073378477;
            4'd11:   c = 30'd1073560135;
            4'd12:   c = 30'd1073650976;
            4'd13:   c = 30'd1073696399;
            4'd14:   c = 30'd1073719111;
            4'd15:   c = 30'd1073730468;
            default: c = 30'd1073730468;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/ard_gk_stream_if.sv =====
// valid/ready stream channel
interface ard_gk_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ard_gaussian_kernel.sv =====
// top level of the ard squared-exponential kernel
//
// i_in carries one feature dimension per transfer: both coordinates, the
// inverse length scale and the skip, on_diagonal and last flags. o_out
// carries one kernel value and a saturation flag per vector pair, sent
// after the transfer marked last. i_cfg_we/i_cfg_idx/i_cfg_wdata write
// signal_variance (index 0) and noise_variance (index 1); the user must
// write them only while idle (not enforced by the block). a dimension
// runs scale, square and accumulate; i_in.ready rises again after a
// transfer without last. the last dimension runs the accumulate, a split
// 40x17 multiply and a 16-step iterative 2^-f unit, and its result is
// loaded into the output register before the next item is taken. reset
// clears the distance sum, the saturation flag and the output valid and
// loads signal_variance 1.0 and noise_variance 0. a stalled o_out holds
// its result; input keeps flowing until the next result is ready, then
// the block waits for the pending one to leave.
module ard_gaussian_kernel (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ard_gk_stream_if.sink                    i_in,
    ard_gk_stream_if.source                  o_out,
    input  logic                             i_cfg_we,
    input  logic [ard_gk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ard_gk_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import ard_gk_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    ard_gk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ard_gk_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data),
        .i_out_ready (o_out.ready)
    );

endmodule

// ===== hdl/ard_gk_ctrl.sv =====
// sequencing controller of the ard gaussian kernel
module ard_gk_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ard_gk_pkg::t_dp_status i_status,
    output ard_gk_pkg::t_dp_cmd    o_cmd
);
    import ard_gk_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SCALE   = 11'b000_0000_0010,
        S_SQUARE  = 11'b000_0000_0100,
        S_ACCUM   = 11'b000_0000_1000,
        S_LOG_LO  = 11'b000_0001_0000,
        S_LOG_HI  = 11'b000_0010_0000,
        S_LOG_SUM = 11'b000_0100_0000,
        S_EXP     = 11'b000_1000_0000,
        S_EXP_FIN = 11'b001_0000_0000,
        S_AMP     = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.last ? S_LOG_LO : S_IDLE;
            end
            S_LOG_LO: begin
                o_cmd.log_lo = 1'b1;
                n_state      = S_LOG_HI;
            end
            S_LOG_HI: begin
                o_cmd.log_hi = 1'b1;
                n_state      = S_LOG_SUM;
            end
            S_LOG_SUM: begin
                o_cmd.log_sum = 1'b1;
                n_state       = S_EXP;
            end
            S_EXP: begin
                o_cmd.exp_step = 1'b1;
                if (i_status.exp_last) begin
                    n_state = S_EXP_FIN;
                end
            end
            S_EXP_FIN: begin
                o_cmd.exp_final = 1'b1;
                n_state         = S_AMP;
            end
            S_AMP: begin
                o_cmd.amp = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/ard_gk_datapath.sv =====
// distance accumulator, exponential and output register of the ard gaussian kernel
`include "ard_gaussian_kernel_defines.svh"

module ard_gk_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ard_gk_pkg::t_dp_cmd                 i_cmd,
    output ard_gk_pkg::t_dp_status              o_status,
    input  ard_gk_pkg::t_in_item                i_in_data,
    input  logic                                i_cfg_we,
    input  logic [ard_gk_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ard_gk_pkg::CFG_W-1:0]        i_cfg_wdata,
    output logic                                o_out_valid,
    output ard_gk_pkg::t_out_item               o_out_data,
    input  logic                                i_out_ready
);
    import ard_gk_pkg::*;

    logic [15:0]       r_sv;
    logic [15:0]       r_nv;
    logic signed [15:0] r_a;
    logic signed [15:0] r_b;
    logic [15:0]       r_theta;
    logic              r_skip;
    logic              r_diag;
    logic              r_last;
    logic [31:0]       r_prod;
    logic [29:0]       r_sq;
    logic              r_sat_d;
    logic [SUM_W-1:0]  r_sum;
    logic              r_sat_seen;
    logic [36:0]       r_plo;
    logic [36:0]       r_phi;
    logic              r_zero;
    logic [4:0]        r_n;
    logic [15:0]       r_f;
    logic [30:0]       r_r;
    logic [3:0]        r_j;
    logic [16:0]       r_e;
    logic [32:0]       r_k;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic signed [16:0] n_diff;
    logic signed [16:0] n_neg;
    logic [15:0]       n_mag;
    logic [32:0]       n_round;
    logic [20:0]       n_s_full;
    logic              n_sat_d;
    logic [14:0]       n_s;
    logic [SUM_W:0]    n_acc;
    logic [56:0]       n_y;
    logic [3:0]        n_bit;
    logic [60:0]       n_step;
    logic [4:0]        n_rnd_sh;
    logic [4:0]        n_sh;
    logic [31:0]       n_exp_sum;
    logic [31:0]       n_exp_val;
    logic [33:0]       n_kern;

    always_comb begin
        n_diff    = {r_a[15], r_a} - {r_b[15], r_b};
        n_neg     = -n_diff;
        n_mag     = n_diff[16] ? n_neg[15:0] : n_diff[15:0];
        n_round   = {1'b0, r_prod} + 33'd2048;
        n_s_full  = n_round[32:12];
        n_sat_d   = |n_s_full[20:15];
        n_s       = n_sat_d ? DIFF_MAX : n_s_full[14:0];
        n_acc     = {1'b0, r_sum} + {11'd0, r_sq};
        n_y       = {r_phi, 20'd0} + {20'd0, r_plo};
        n_bit     = 4'd15 - r_j;
        n_step    = 61'(r_r) * 61'(pow2_neg_frac(r_j)) + EXP_RND;
        n_rnd_sh  = r_n + 5'd13;
        n_sh      = r_n + 5'd14;
        n_exp_sum = 32'(r_r) + (32'd1 << n_rnd_sh);
        n_exp_val = n_exp_sum >> n_sh;
        n_kern    = {1'b0, r_k} + (r_diag ? {2'b00, r_nv, 16'd0} : 34'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= SV_RESET;
            r_nv <= NV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIGNAL_VAR: r_sv <= i_cfg_wdata;
                CFG_NOISE_VAR:  r_nv <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // item capture, front arithmetic, logarithm, exponent result, amplitude and output data
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= i_in_data.coord_a;
            r_b     <= i_in_data.coord_b;
            r_theta <= i_in_data.inv_length_scale;
            r_skip  <= i_in_data.skip;
            r_diag  <= i_in_data.on_diagonal;
            r_last  <= i_in_data.last;
        end
        if (i_cmd.scale) begin
            r_prod <= 32'(n_mag) * 32'(r_theta);
        end
        if (i_cmd.square) begin
            r_sq    <= 30'(n_s) * 30'(n_s);
            r_sat_d <= n_sat_d;
        end
        if (i_cmd.log_lo) begin
            r_plo <= 37'(r_sum[19:0]) * 37'(LOG2E_Q16);
        end
        if (i_cmd.log_hi) begin
            r_phi <= 37'(r_sum[39:20]) * 37'(LOG2E_Q16);
        end
        if (i_cmd.log_sum) begin
            r_zero <= (n_y[56:33] >= 24'd17);
            r_n    <= n_y[37:33];
            r_f    <= n_y[32:17];
        end
        if (i_cmd.exp_final) begin
            r_e <= r_zero ? 17'd0 : n_exp_val[16:0];
        end
        if (i_cmd.amp) begin
            r_k <= 33'(r_sv) * 33'(r_e);
        end
        if (i_cmd.out_load) begin
            r_out_data.kernel_value <= n_kern[32:0];
            r_out_data.saturated    <= r_sat_seen;
        end
    end

    // distance sum, exponential iteration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sat_seen  <= 1'b0;
            r_r         <= EXP_ONE;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accum && !r_skip) begin
                r_sum      <= n_acc[SUM_W] ? SUM_MAX : n_acc[SUM_W-1:0];
                r_sat_seen <= r_sat_seen | r_sat_d | n_acc[SUM_W];
            end else if (i_cmd.out_load) begin
                r_sum      <= '0;
                r_sat_seen <= 1'b0;
            end
            if (i_cmd.log_sum) begin
                r_r <= EXP_ONE;
                r_j <= '0;
            end else if (i_cmd.exp_step) begin
                if (r_f[n_bit]) begin
                    r_r <= n_step[60:30];
                end
                r_j <= r_j + 4'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.last     = r_last;
    assign o_status.exp_last = (r_j == 4'd15);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

    `ARD_GK_ASSERT_NEXT(a_sum_cleared, i_clk, i_rst_n, i_cmd.out_load, (r_sum == '0) && !r_sat_seen, "distance sum not cleared after result")
    `ARD_GK_ASSERT_NOW(a_exp_range, i_clk, i_rst_n, 1'b1, r_r <= EXP_ONE, "exponential mantissa above one")
    `ARD_GK_ASSERT_NEXT(a_step_count, i_clk, i_rst_n, i_cmd.exp_step && (r_j != 4'd15), r_j == $past(r_j) + 4'd1, "exponential step counter skipped")
    `ARD_GK_ASSERT_NOW(a_out_slot, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_out_ready, "result overwrites pending transfer")
    `ARD_GK_ASSERT_NOW(a_exp_max, i_clk, i_rst_n, i_cmd.amp, r_e <= EXP_MAX, "exponential above one")

endmodule
